// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// ===== rtl/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// Types and fixed widths for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;
	localparam int AXES    = 3;
	localparam int SCALE_W = 30;  // normalized magnitude, top in [2^29, 2^30)
	localparam int SQ_W    = 60;
	localparam int SUM_W   = 62;
	localparam int ROOT_W  = 31;
	localparam int OUT_W   = 16;

	typedef struct packed {
		logic [AXES-1:0] neg;
		logic            degen;
	} side_t;
endpackage

// ===== rtl/tfn_cross.sv =====
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, partial products and cross product magnitudes (3 stages).
// ----------------------------------------------------------------------------
module tfn_cross import tfn_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	localparam int ES = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0,
	localparam int EW = COORD_WIDTH + 1 - ES,
	localparam int MW = 2 * EW
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [COORD_WIDTH-1:0] vtx [9],
	output logic                   out_valid,
	output logic [MW-1:0]          mag [AXES],
	output side_t                  side
);
	localparam logic [COORD_WIDTH:0] BIAS = (COORD_WIDTH + 1)'((64'd1 << ES) - 64'd1);

	// difference, divided by 2^ES toward zero for wide coordinates
	function automatic logic signed [EW-1:0] edge_of(input logic [COORD_WIDTH-1:0] t,
			input logic [COORD_WIDTH-1:0] f);
		logic signed [COORD_WIDTH:0] d;
		logic signed [COORD_WIDTH:0] b;
		d = $signed({t[COORD_WIDTH-1], t}) - $signed({f[COORD_WIDTH-1], f});
		b = d + (d[COORD_WIDTH] ? $signed(BIAS) : '0);
		b = b >>> ES;
		return b[EW-1:0];
	endfunction

	logic                 v_s1, v_s2, v_s3;
	logic signed [EW-1:0] e1_s1 [AXES];
	logic signed [EW-1:0] e2_s1 [AXES];
	logic signed [MW-1:0] p_s2 [6];
	logic [MW-1:0]        mag_s3 [AXES];
	logic [AXES-1:0]      neg_s3;
	logic signed [MW:0]   cr [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < AXES; i++) begin
				e1_s1[i] <= edge_of(vtx[3 + i], vtx[i]);
				e2_s1[i] <= edge_of(vtx[6 + i], vtx[i]);
			end
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
			for (int i = 0; i < AXES; i++) begin
				neg_s3[i] <= cr[i][MW];
				mag_s3[i] <= cr[i][MW] ? MW'(-cr[i]) : cr[i][MW-1:0];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < AXES; i++)
			cr[i] = {p_s2[2*i][MW-1], p_s2[2*i]} - {p_s2[2*i+1][MW-1], p_s2[2*i+1]};
	end

	assign out_valid  = v_s3;
	assign mag        = mag_s3;
	assign side.neg   = neg_s3;
	assign side.degen = 1'b0;
endmodule

// ===== rtl/tfn_scale.sv =====
// ----------------------------------------------------------------------------
// tfn_scale
// Largest component, normalize to [2^29, 2^30), squares and their sum (5 stages).
// ----------------------------------------------------------------------------
module tfn_scale import tfn_pkg::*; #(
	parameter int MW = 34,
	localparam int PW = $clog2(MW)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [MW-1:0]      in_mag [AXES],
	input  side_t              in_side,
	output logic               out_valid,
	output logic [SCALE_W-1:0] mag [AXES],
	output logic [SUM_W-1:0]   sum,
	output side_t              side
);
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [MW-1:0]      top_s1;
	logic [MW-1:0]      m_s1 [AXES];
	logic [MW-1:0]      m_s2 [AXES];
	logic [PW-1:0]      msb_s2;
	logic [SCALE_W-1:0] m_s3 [AXES];
	logic [SCALE_W-1:0] m_s4 [AXES];
	logic [SCALE_W-1:0] m_s5 [AXES];
	logic [SQ_W-1:0]    sq_s4 [AXES];
	logic [SUM_W-1:0]   sum_s5;
	side_t              sd_s1, sd_s2, sd_s3, sd_s4, sd_s5;
	logic [MW-1:0]      top_c;
	logic [PW-1:0]      msb_c;
	logic [MW+28:0]     wide [AXES];

	always_comb begin
		top_c = (in_mag[0] > in_mag[1]) ? in_mag[0] : in_mag[1];
		if (in_mag[2] > top_c)
			top_c = in_mag[2];
		msb_c = '0;
		for (int b = 0; b < MW; b++)
			if (top_s1[b])
				msb_c = PW'(b);
		// (mag << 29) >> msb: left exact, right truncating
		for (int i = 0; i < AXES; i++)
			wide[i] = {m_s2[i], 29'b0} >> msb_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			top_s1 <= top_c;
			m_s1   <= in_mag;
			sd_s1  <= in_side;

			msb_s2 <= msb_c;
			m_s2   <= m_s1;
			sd_s2  <= '{neg: sd_s1.neg, degen: (top_s1 == '0)};

			for (int i = 0; i < AXES; i++)
				m_s3[i] <= wide[i][SCALE_W-1:0];
			sd_s3 <= sd_s2;

			for (int i = 0; i < AXES; i++)
				sq_s4[i] <= m_s3[i] * m_s3[i];
			m_s4  <= m_s3;
			sd_s4 <= sd_s3;

			sum_s5 <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
			m_s5   <= m_s4;
			sd_s5  <= sd_s4;
		end
	end

	assign out_valid = v_s5;
	assign mag       = m_s5;
	assign sum       = sum_s5;
	assign side      = sd_s5;
endmodule

// ===== rtl/tfn_sqrt.sv =====
// ----------------------------------------------------------------------------
// tfn_sqrt
// Floor square root, one root bit per stage, MSB first.
// ----------------------------------------------------------------------------
module tfn_sqrt import tfn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [SUM_W-1:0]   in_sum,
	input  logic [SCALE_W-1:0] in_mag [AXES],
	input  side_t              in_side,
	output logic               out_valid,
	output logic [ROOT_W-1:0]  root,
	output logic [SCALE_W-1:0] mag [AXES],
	output side_t              side
);
	logic               v_s   [ROOT_W];
	logic [SUM_W-1:0]   rem_s [ROOT_W];
	logic [ROOT_W-1:0]  rt_s  [ROOT_W];
	logic [SCALE_W-1:0] m_s   [ROOT_W][AXES];
	side_t              sd_s  [ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		localparam int K = ROOT_W - 1 - i;
		logic               v_in;
		logic [SUM_W-1:0]   rem_in;
		logic [ROOT_W-1:0]  rt_in;
		logic [SCALE_W-1:0] m_in [AXES];
		side_t              sd_in;
		logic [SUM_W:0]     trial;
		logic               take;

		if (i == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = in_sum;
			assign rt_in  = '0;
			assign m_in   = in_mag;
			assign sd_in  = in_side;
		end else begin : g_next
			assign v_in   = v_s[i-1];
			assign rem_in = rem_s[i-1];
			assign rt_in  = rt_s[i-1];
			assign m_in   = m_s[i-1];
			assign sd_in  = sd_s[i-1];
		end

		// (root + 2^K)^2 - root^2, root having no bits at or below K
		assign trial = ((SUM_W + 1)'(rt_in) << (K + 1)) + ((SUM_W + 1)'(1) << (2 * K));
		assign take  = ({1'b0, rem_in} >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i] <= 1'b0;
			else if (en)
				v_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? SUM_W'({1'b0, rem_in} - trial) : rem_in;
				rt_s[i]  <= take ? (rt_in | (ROOT_W'(1) << K)) : rt_in;
				m_s[i]   <= m_in;
				sd_s[i]  <= sd_in;
			end
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign root      = rt_s[ROOT_W-1];
	assign mag       = m_s[ROOT_W-1];
	assign side      = sd_s[ROOT_W-1];
endmodule

// ===== rtl/tfn_div.sv =====
// ----------------------------------------------------------------------------
// tfn_div
// Rounded quotient (mag * 2^F + L/2) / L, three lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tfn_div import tfn_pkg::*; #(
	parameter int FRAC = 14,
	localparam int QW = FRAC + 1,
	localparam int NW = SCALE_W + FRAC + 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [ROOT_W-1:0]  in_root,
	input  logic [SCALE_W-1:0] in_mag [AXES],
	input  side_t              in_side,
	output logic               out_valid,
	output logic [QW-1:0]      quo [AXES],
	output side_t              side
);
	logic              v_s0;
	logic [NW-1:0]     num_s0 [AXES];
	logic [ROOT_W-1:0] len_s0;
	side_t             sd_s0;

	logic              v_s   [QW];
	logic [NW-1:0]     rem_s [QW][AXES];
	logic [QW-1:0]     q_s   [QW][AXES];
	logic [ROOT_W-1:0] len_s [QW];
	side_t             sd_s  [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s0 <= 1'b0;
		else if (en)
			v_s0 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++)
				num_s0[a] <= (NW'(in_mag[a]) << FRAC) + NW'(in_root >> 1);
			len_s0 <= in_root;
			sd_s0  <= in_side;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		localparam int J = QW - 1 - i;
		logic              v_in;
		logic [NW-1:0]     rem_in [AXES];
		logic [QW-1:0]     q_in   [AXES];
		logic [ROOT_W-1:0] len_in;
		side_t             sd_in;
		logic [NW-1:0]     dv;

		if (i == 0) begin : g_first
			assign v_in   = v_s0;
			assign rem_in = num_s0;
			assign len_in = len_s0;
			assign sd_in  = sd_s0;
			for (genvar a = 0; a < AXES; a++) begin : g_q0
				assign q_in[a] = '0;
			end
		end else begin : g_next
			assign v_in   = v_s[i-1];
			assign rem_in = rem_s[i-1];
			assign q_in   = q_s[i-1];
			assign len_in = len_s[i-1];
			assign sd_in  = sd_s[i-1];
		end

		assign dv = NW'(len_in) << J;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i] <= 1'b0;
			else if (en)
				v_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int a = 0; a < AXES; a++) begin
					if (rem_in[a] >= dv) begin
						rem_s[i][a] <= rem_in[a] - dv;
						q_s[i][a]   <= q_in[a] | (QW'(1) << J);
					end else begin
						rem_s[i][a] <= rem_in[a];
						q_s[i][a]   <= q_in[a];
					end
				end
				len_s[i] <= len_in;
				sd_s[i]  <= sd_in;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign quo       = q_s[QW-1];
	assign side      = sd_s[QW-1];
endmodule

// ===== rtl/triangle_face_normal_top.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal_top
// Unit face normal of a triangle, fully pipelined, one triangle per clock while s_tready is high.
// ----------------------------------------------------------------------------
// Slave channel (s_*) carries one triangle per transaction: nine signed
// coordinates A, B, C. Master channel (m_*) returns one transaction per
// triangle, in order: the unit normal in signed Q1.14 and, on m_tuser, the
// degenerate flag (zero-area triangle, normal forced to zero).
// Throughput: one triangle per clock while s_tready is high; every stage is a
// register slice and there is no iterative unit. From input transaction to
// m_tvalid a triangle passes edges and cross product, normalization and sum
// of squares, square root (one root bit per stage), divide (one quotient
// bit per stage) and the output register.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls, the output register holds its transaction and a
// one-entry skid register catches the next; the pipeline then freezes and
// s_tready drops until the skid entry drains. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module triangle_face_normal_top import tfn_pkg::*; #(
	parameter int COORD_WIDTH      = 16,
	parameter int NORMAL_FRAC_BITS = 14,
	localparam int IN_W  = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (COORD_WIDTH each), zero pad
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// norm_x, norm_y, norm_z
	output logic [3*OUT_W-1:0] m_tdata,
	// degenerate
	output logic              m_tuser
);
	`include "assert_macros.svh"

	localparam int ES = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
	localparam int MW = 2 * (COORD_WIDTH + 1 - ES);
	localparam int QW = NORMAL_FRAC_BITS + 1;
	localparam int XW = (QW > OUT_W) ? QW : OUT_W;

	logic                   en;
	logic [COORD_WIDTH-1:0] vtx [9];

	logic               cr_valid;
	logic [MW-1:0]      cr_mag [AXES];
	side_t              cr_side;
	logic               sc_valid;
	logic [SCALE_W-1:0] sc_mag [AXES];
	logic [SUM_W-1:0]   sc_sum;
	side_t              sc_side;
	logic               sq_valid;
	logic [ROOT_W-1:0]  sq_root;
	logic [SCALE_W-1:0] sq_mag [AXES];
	side_t              sq_side;
	logic               dv_valid;
	logic [QW-1:0]      dv_quo [AXES];
	side_t              dv_side;

	logic [3*OUT_W-1:0] res_data;
	logic [XW-1:0]      qx [AXES];
	logic               out_v_q, skid_v_q;
	logic [3*OUT_W-1:0] out_data_q, skid_data_q;
	logic               out_user_q, skid_user_q;

	for (genvar i = 0; i < 9; i++) begin : g_unpack
		assign vtx[i] = s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
	end

	assign en       = !skid_v_q;
	assign s_tready = en;

	tfn_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
		.clk, .arst_n, .en,
		.in_valid (s_tvalid && s_tready),
		.vtx,
		.out_valid(cr_valid),
		.mag      (cr_mag),
		.side     (cr_side)
	);

	tfn_scale #(.MW(MW)) u_scale (
		.clk, .arst_n, .en,
		.in_valid (cr_valid),
		.in_mag   (cr_mag),
		.in_side  (cr_side),
		.out_valid(sc_valid),
		.mag      (sc_mag),
		.sum      (sc_sum),
		.side     (sc_side)
	);

	tfn_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.in_valid (sc_valid),
		.in_sum   (sc_sum),
		.in_mag   (sc_mag),
		.in_side  (sc_side),
		.out_valid(sq_valid),
		.root     (sq_root),
		.mag      (sq_mag),
		.side     (sq_side)
	);

	tfn_div #(.FRAC(NORMAL_FRAC_BITS)) u_div (
		.clk, .arst_n, .en,
		.in_valid (sq_valid),
		.in_root  (sq_root),
		.in_mag   (sq_mag),
		.in_side  (sq_side),
		.out_valid(dv_valid),
		.quo      (dv_quo),
		.side     (dv_side)
	);

	// apply sign, keep the low OUT_W bits, zero on a degenerate triangle
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			qx[a] = XW'(dv_quo[a]);
			if (dv_side.neg[a])
				qx[a] = -qx[a];
			res_data[a*OUT_W +: OUT_W] = dv_side.degen ? '0 : qx[a][OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_tready || !out_v_q) begin
			out_v_q  <= skid_v_q || dv_valid;
			skid_v_q <= 1'b0;
		end else if (dv_valid && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_v_q) begin
			out_data_q <= skid_v_q ? skid_data_q : res_data;
			out_user_q <= skid_v_q ? skid_user_q : dv_side.degen;
		end else if (dv_valid && en) begin
			skid_data_q <= res_data;
			skid_user_q <= dv_side.degen;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	`ASSERT_IMP(a_degen_zero, m_tvalid && m_tuser, m_tdata == '0)
	`ASSERT_NXT(a_skid_drains, skid_v_q, out_v_q)
	`ASSERT_IMP(a_skid_fill, $rose(skid_v_q), $past(out_v_q) && !$past(m_tready))
endmodule
